[hw/rtl/aabbfc_pkg.sv]
// ----------------------------------------------------------------------------
// aabbfc_pkg
// Types and fixed constants shared by the frustum cull datapath.
// ----------------------------------------------------------------------------
package aabbfc_pkg;

    localparam int ENTRY_W     = 32;
    localparam int NORM_W      = ENTRY_W + 1;
    localparam int COORD_W     = 16;
    localparam int IDX_W       = 2;
    localparam int AXES        = 3;
    localparam int PLANE_COUNT = 6;

    localparam logic             FUNC_LOAD = 1'b0;
    localparam logic             FUNC_TEST = 1'b1;
    localparam logic [IDX_W-1:0] LAST_ROW  = 2'd3;
    localparam logic [IDX_W-1:0] DIST_COL  = 2'd3;

    typedef struct packed {
        logic [AXES-1:0][NORM_W-1:0] n;
        logic [NORM_W-1:0]           d;
    } plane_t;

    typedef plane_t [PLANE_COUNT-1:0] plane_set_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ENTRY_W-1:0] value;
    } mat_wr_t;

endpackage

[hw/rtl/aabbfc_matrix.sv]
// ----------------------------------------------------------------------------
// aabbfc_matrix
// View-projection matrix store and derivation of the six frustum planes.
// ----------------------------------------------------------------------------
module aabbfc_matrix
(
    input  logic                clk,
    input  logic                rst_n,
    input  aabbfc_pkg::mat_wr_t wr,
    output aabbfc_pkg::plane_set_t planes
);
    import aabbfc_pkg::*;

    logic [ENTRY_W-1:0] entry_reg [4][4];

    function automatic logic [NORM_W-1:0] comb_entry(
        input logic [ENTRY_W-1:0] base,
        input logic [ENTRY_W-1:0] other,
        input logic               add
    );
        logic signed [NORM_W-1:0] a;
        logic signed [NORM_W-1:0] b;
        a = NORM_W'($signed(base));
        b = NORM_W'($signed(other));
        return add ? (a + b) : (a - b);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    entry_reg[r][c] <= '0;
                end
            end
        end
        else if (wr.we)
        begin
            entry_reg[wr.row][wr.col] <= wr.value;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        localparam logic [IDX_W-1:0] ROW = IDX_W'(p / 2);
        localparam logic             ADD = ((p % 2) == 1);

        for (genvar c = 0; c < AXES; c++)
        begin : g_axis
            localparam logic [IDX_W-1:0] COL = IDX_W'(c);
            assign planes[p].n[c] = comb_entry(entry_reg[LAST_ROW][COL],
                                               entry_reg[ROW][COL], ADD);
        end

        assign planes[p].d = comb_entry(entry_reg[LAST_ROW][DIST_COL],
                                        entry_reg[ROW][DIST_COL], ADD);
    end

endmodule

[hw/rtl/aabbfc_product.sv]
// ----------------------------------------------------------------------------
// aabbfc_product
// Input register for test items, p-vertex selection and the plane products.
// ----------------------------------------------------------------------------
module aabbfc_product
#(
    parameter int CHUNK_EDGE = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         test_in,
    input  logic [aabbfc_pkg::COORD_W-1:0] coord_x,
    input  logic [aabbfc_pkg::COORD_W-1:0] coord_y,
    input  logic [aabbfc_pkg::COORD_W-1:0] coord_z,
    input  aabbfc_pkg::plane_set_t       planes,
    output logic                         prod_valid,
    output logic [aabbfc_pkg::COORD_W+$clog2(CHUNK_EDGE+1)+aabbfc_pkg::NORM_W-1:0]
                                         prod [aabbfc_pkg::PLANE_COUNT][aabbfc_pkg::AXES],
    output logic [aabbfc_pkg::NORM_W-1:0] plane_d [aabbfc_pkg::PLANE_COUNT]
);
    import aabbfc_pkg::*;

    localparam int CORNER_W = COORD_W + $clog2(CHUNK_EDGE + 1);
    localparam int PROD_W   = CORNER_W + NORM_W;
    localparam logic signed [CORNER_W-1:0] EDGE_S = CORNER_W'(CHUNK_EDGE);

    logic               test_reg;
    logic [COORD_W-1:0] coord_reg [AXES];
    logic               prod_valid_reg;
    logic [PROD_W-1:0]  prod_reg [PLANE_COUNT][AXES];
    logic [NORM_W-1:0]  dist_reg [PLANE_COUNT];

    logic signed [CORNER_W-1:0] lo [AXES];
    logic signed [CORNER_W-1:0] hi [AXES];
    logic [PROD_W-1:0]          prod_next [PLANE_COUNT][AXES];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            lo[a] = CORNER_W'($signed(coord_reg[a])) * EDGE_S;
            hi[a] = lo[a] + EDGE_S;
        end
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_next[p][a] = PROD_W'($signed(planes[p].n[a]))
                                * PROD_W'(planes[p].n[a][NORM_W-1] ? lo[a] : hi[a]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_reg       <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            test_reg       <= test_in;
            prod_valid_reg <= test_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            coord_reg[0] <= coord_x;
            coord_reg[1] <= coord_y;
            coord_reg[2] <= coord_z;
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                dist_reg[p] <= planes[p].d;
                for (int a = 0; a < AXES; a++)
                begin
                    prod_reg[p][a] <= prod_next[p][a];
                end
            end
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;
    assign plane_d    = dist_reg;

endmodule

[hw/rtl/aabbfc_decide.sv]
// ----------------------------------------------------------------------------
// aabbfc_decide
// Per-plane signed distance of the p-vertex and the final cull decision.
// ----------------------------------------------------------------------------
module aabbfc_decide
#(
    parameter int CHUNK_EDGE = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          prod_valid,
    input  logic [aabbfc_pkg::COORD_W+$clog2(CHUNK_EDGE+1)+aabbfc_pkg::NORM_W-1:0]
                                          prod [aabbfc_pkg::PLANE_COUNT][aabbfc_pkg::AXES],
    input  logic [aabbfc_pkg::NORM_W-1:0] plane_d [aabbfc_pkg::PLANE_COUNT],
    output logic                          result_valid,
    output logic                          visible
);
    import aabbfc_pkg::*;

    localparam int PROD_W = COORD_W + $clog2(CHUNK_EDGE + 1) + NORM_W;
    localparam int SUM_W  = PROD_W + 2;

    logic              result_valid_reg;
    logic              visible_reg;
    logic              visible_next;
    logic signed [SUM_W-1:0] acc [PLANE_COUNT];

    always_comb
    begin
        visible_next = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            acc[p] = SUM_W'($signed(plane_d[p]))
                   + SUM_W'($signed(prod[p][0]))
                   + SUM_W'($signed(prod[p][1]))
                   + SUM_W'($signed(prod[p][2]));
            if (acc[p][SUM_W-1])
            begin
                visible_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            visible_reg <= visible_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign visible      = visible_reg;

endmodule

[hw/rtl/aabb_frustum_cull_unit.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_unit
// Frustum culling of cubic chunk boxes against a loaded view-projection matrix.
//
// Input channel item_valid / item_stall: func selects a matrix entry load or a
// chunk test. A load writes entry (matrix_row, matrix_column) at acceptance
// and gives no result; a later test sees it. A test gives one result item.
// Result channel result_valid / result_stall carries in_frustum.
// A test passes the input, product and result registers in that order; its
// result then waits in the result register until it is taken.
// Throughput: one item per cycle while no result is stalled, set by the
// three-stage pipeline; a test's 18 plane products are formed side by side in
// one stage. While result_stall holds a waiting result, the whole pipeline
// holds and item_stall is raised; nothing is dropped.
// Reset clears the matrix to zero, so every chunk then reads as visible, and
// empties the pipeline.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_unit
#(
    parameter int CHUNK_EDGE = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          func,
    input  logic [1:0]                    matrix_column,
    input  logic [1:0]                    matrix_row,
    input  logic signed [31:0]            matrix_value,
    input  logic signed [15:0]            chunk_x,
    input  logic signed [15:0]            chunk_y,
    input  logic signed [15:0]            chunk_z,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          in_frustum
);
    import aabbfc_pkg::*;

    localparam int PROD_W = COORD_W + $clog2(CHUNK_EDGE + 1) + NORM_W;

    logic       advance;
    logic       accept;
    mat_wr_t    wr;
    plane_set_t planes;
    logic       prod_valid;
    logic [PROD_W-1:0] prod [PLANE_COUNT][AXES];
    logic [NORM_W-1:0] plane_d [PLANE_COUNT];

    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;
    assign accept     = item_valid && advance;

    assign wr.we    = accept && (func == FUNC_LOAD);
    assign wr.row   = matrix_row;
    assign wr.col   = matrix_column;
    assign wr.value = matrix_value;

    aabbfc_matrix u_matrix
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .planes (planes)
    );

    aabbfc_product #(.CHUNK_EDGE(CHUNK_EDGE)) u_product
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .test_in    (accept && (func == FUNC_TEST)),
        .coord_x    (chunk_x),
        .coord_y    (chunk_y),
        .coord_z    (chunk_z),
        .planes     (planes),
        .prod_valid (prod_valid),
        .prod       (prod),
        .plane_d    (plane_d)
    );

    aabbfc_decide #(.CHUNK_EDGE(CHUNK_EDGE)) u_decide
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .prod_valid   (prod_valid),
        .prod         (prod),
        .plane_d      (plane_d),
        .result_valid (result_valid),
        .visible      (in_frustum)
    );

endmodule
